// ===== hdl/fupa_pkg.sv =====
// Shared types, codes and defaults for the fixed unit pool allocator.
`default_nettype none

package fupa_pkg;

    localparam int UNITS_DEF      = 64;
    localparam int UNIT_BYTES_W   = 16;
    localparam int REQ_BYTES_W    = 32;
    localparam int HANDLE_W       = 7;
    localparam int IDX_W          = 6;
    localparam int STATUS_W       = 2;

    localparam logic [UNIT_BYTES_W-1:0] UNIT_BYTES_RST = 16'd64;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_GRANT    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ALLOC_FB = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RETURNED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FREE_FB  = 2'd3;

    typedef struct packed {
        logic                   operation;
        logic [REQ_BYTES_W-1:0] request_bytes;
        logic [HANDLE_W-1:0]    handle;
    } pool_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    unit_index;
    } pool_rsp_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_FIX
    } fupa_state_t;

endpackage

`default_nettype wire

// ===== hdl/fixed_unit_pool_allocator.sv =====
// Top level of the fixed unit pool allocator: sequencer plus three link memories.
// A new item is taken only in S_IDLE; the result strobe done_reg is set in S_EXEC.
// Release and fall-back items go back to idle from S_EXEC; a grant onto a non-empty
// used list passes through S_FIX for the second write to the used_prev memory.
// Reset: asynchronous, active low. A clearing pass (S_CLEAR) then builds the free
// list in its memory, with busy high; configuration writes are taken throughout.
// The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none

module fixed_unit_pool_allocator #(
    parameter int UNITS = fupa_pkg::UNITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire fupa_pkg::pool_req_t               request,
    output logic                                   done,
    output fupa_pkg::pool_rsp_t                    result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fupa_pkg::UNIT_BYTES_W-1:0] cfg_data
);

    import fupa_pkg::*;

    localparam int IW = $clog2(UNITS);
    localparam int LW = $clog2(UNITS + 1);

    logic          fl_we, un_we, up_we;
    logic [IW-1:0] fl_waddr, un_waddr, up_waddr;
    logic [IW-1:0] fl_raddr, un_raddr, up_raddr;
    logic [LW-1:0] fl_wdata, un_wdata, up_wdata;
    logic [LW-1:0] fl_rdata, un_rdata, up_rdata;

    fupa_ctrl #(
        .UNITS(UNITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .fl_we    (fl_we),
        .fl_waddr (fl_waddr),
        .fl_wdata (fl_wdata),
        .fl_raddr (fl_raddr),
        .fl_rdata (fl_rdata),
        .un_we    (un_we),
        .un_waddr (un_waddr),
        .un_wdata (un_wdata),
        .un_raddr (un_raddr),
        .un_rdata (un_rdata),
        .up_we    (up_we),
        .up_waddr (up_waddr),
        .up_wdata (up_wdata),
        .up_raddr (up_raddr),
        .up_rdata (up_rdata)
    );

    fupa_ram #(
        .DEPTH(UNITS),
        .WIDTH(LW)
    ) u_free_link (
        .clk  (clk),
        .we   (fl_we),
        .waddr(fl_waddr),
        .wdata(fl_wdata),
        .raddr(fl_raddr),
        .rdata(fl_rdata)
    );

    fupa_ram #(
        .DEPTH(UNITS),
        .WIDTH(LW)
    ) u_used_next (
        .clk  (clk),
        .we   (un_we),
        .waddr(un_waddr),
        .wdata(un_wdata),
        .raddr(un_raddr),
        .rdata(un_rdata)
    );

    fupa_ram #(
        .DEPTH(UNITS),
        .WIDTH(LW)
    ) u_used_prev (
        .clk  (clk),
        .we   (up_we),
        .waddr(up_waddr),
        .wdata(up_wdata),
        .raddr(up_raddr),
        .rdata(up_rdata)
    );

endmodule

`default_nettype wire

// ===== hdl/fupa_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module fupa_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/fupa_ctrl.sv =====
// Sequencer: list heads, config register, link read-modify-write and result register.
`default_nettype none

module fupa_ctrl #(
    parameter int UNITS = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire fupa_pkg::pool_req_t                     request,
    output logic                                         done,
    output fupa_pkg::pool_rsp_t                          result,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [fupa_pkg::UNIT_BYTES_W-1:0]       cfg_data,
    // free_link memory
    output logic                                         fl_we,
    output logic [$clog2(UNITS)-1:0]                     fl_waddr,
    output logic [$clog2(UNITS+1)-1:0]                   fl_wdata,
    output logic [$clog2(UNITS)-1:0]                     fl_raddr,
    input  wire logic [$clog2(UNITS+1)-1:0]              fl_rdata,
    // used_next memory
    output logic                                         un_we,
    output logic [$clog2(UNITS)-1:0]                     un_waddr,
    output logic [$clog2(UNITS+1)-1:0]                   un_wdata,
    output logic [$clog2(UNITS)-1:0]                     un_raddr,
    input  wire logic [$clog2(UNITS+1)-1:0]              un_rdata,
    // used_prev memory
    output logic                                         up_we,
    output logic [$clog2(UNITS)-1:0]                     up_waddr,
    output logic [$clog2(UNITS+1)-1:0]                   up_wdata,
    output logic [$clog2(UNITS)-1:0]                     up_raddr,
    input  wire logic [$clog2(UNITS+1)-1:0]              up_rdata
);

    import fupa_pkg::*;

    localparam int IW = $clog2(UNITS);
    localparam int LW = $clog2(UNITS + 1);
    localparam int XW = (LW > HANDLE_W) ? LW : HANDLE_W;
    localparam logic [LW-1:0] NIL = LW'(UNITS);

    fupa_state_t              state_reg, state_next;
    logic [LW-1:0]            free_head_reg, free_head_next;
    logic [LW-1:0]            used_head_reg, used_head_next;
    logic [UNIT_BYTES_W-1:0]  unit_bytes_reg, unit_bytes_next;
    logic [IW-1:0]            clr_reg, clr_next;
    logic                     op_reg, op_next;
    logic                     fb_reg, fb_next;
    logic [IW-1:0]            hnd_reg, hnd_next;
    logic [IW-1:0]            fix_addr_reg, fix_addr_next;
    logic [LW-1:0]            fix_data_reg, fix_data_next;
    logic                     done_reg, done_next;
    pool_rsp_t                rsp_reg, rsp_next;

    logic [XW-1:0]            h_ext;
    logic                     h_in_pool;
    logic [XW-1:0]            u_ext;
    logic                     free_head_ok;
    logic                     used_head_ok;
    logic                     p_ok;
    logic                     n_ok;

    assign h_ext        = XW'(request.handle);
    assign h_in_pool    = h_ext < XW'(UNITS);
    assign u_ext        = XW'(free_head_reg);
    assign free_head_ok = free_head_reg < NIL;
    assign used_head_ok = used_head_reg < NIL;
    assign p_ok         = up_rdata < NIL;
    assign n_ok         = un_rdata < NIL;

    assign busy      = state_reg != S_IDLE;
    assign done      = done_reg;
    assign result    = rsp_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            free_head_reg  <= LW'(UNITS - 1);
            used_head_reg  <= NIL;
            unit_bytes_reg <= UNIT_BYTES_RST;
            clr_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            used_head_reg  <= used_head_next;
            unit_bytes_reg <= unit_bytes_next;
            clr_reg        <= clr_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        fb_reg       <= fb_next;
        hnd_reg      <= hnd_next;
        fix_addr_reg <= fix_addr_next;
        fix_data_reg <= fix_data_next;
        rsp_reg      <= rsp_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        used_head_next  = used_head_reg;
        unit_bytes_next = unit_bytes_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        fb_next         = fb_reg;
        hnd_next        = hnd_reg;
        fix_addr_next   = fix_addr_reg;
        fix_data_next   = fix_data_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;

        fl_we    = 1'b0;
        fl_waddr = hnd_reg;
        fl_wdata = free_head_reg;
        fl_raddr = free_head_reg[IW-1:0];
        un_we    = 1'b0;
        un_waddr = free_head_reg[IW-1:0];
        un_wdata = used_head_reg;
        un_raddr = h_ext[IW-1:0];
        up_we    = 1'b0;
        up_waddr = free_head_reg[IW-1:0];
        up_wdata = NIL;
        up_raddr = h_ext[IW-1:0];

        if (cfg_valid)
        begin
            unit_bytes_next = cfg_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // free list starts as UNITS-1 -> ... -> 0 -> nil
                fl_we    = 1'b1;
                fl_waddr = clr_reg;
                fl_wdata = (clr_reg == '0) ? NIL : LW'(clr_reg) - LW'(1);
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = request.operation;
                    hnd_next = h_ext[IW-1:0];
                    if (request.operation == OP_ALLOC)
                    begin
                        fb_next = (request.request_bytes > REQ_BYTES_W'(unit_bytes_reg))
                                  || !free_head_ok;
                    end
                    else
                    begin
                        fb_next = !h_in_pool;
                    end
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                rsp_next.unit_index = '0;
                if (op_reg == OP_ALLOC)
                begin
                    if (fb_reg)
                    begin
                        rsp_next.status = STAT_ALLOC_FB;
                    end
                    else
                    begin
                        // pop free head, push it on the front of the used list
                        rsp_next.status     = STAT_GRANT;
                        rsp_next.unit_index = u_ext[IDX_W-1:0];
                        free_head_next      = fl_rdata;
                        used_head_next      = free_head_reg;
                        un_we               = 1'b1;
                        up_we               = 1'b1;
                        if (used_head_ok)
                        begin
                            fix_addr_next = used_head_reg[IW-1:0];
                            fix_data_next = free_head_reg;
                            state_next    = S_FIX;
                        end
                    end
                end
                else
                begin
                    if (fb_reg)
                    begin
                        rsp_next.status = STAT_FREE_FB;
                    end
                    else
                    begin
                        // unlink from used list, push onto free list
                        rsp_next.status = STAT_RETURNED;
                        un_waddr        = up_rdata[IW-1:0];
                        un_wdata        = un_rdata;
                        un_we           = p_ok;
                        if (!p_ok)
                        begin
                            used_head_next = un_rdata;
                        end
                        up_waddr       = un_rdata[IW-1:0];
                        up_wdata       = up_rdata;
                        up_we          = n_ok;
                        fl_we          = 1'b1;
                        fl_waddr       = hnd_reg;
                        fl_wdata       = free_head_reg;
                        free_head_next = LW'(hnd_reg);
                    end
                end
            end
            S_FIX:
            begin
                // back link of the old used head
                up_we      = 1'b1;
                up_waddr   = fix_addr_reg;
                up_wdata   = fix_data_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/fupa_checker.sv =====
// Port-level checks for the allocator and the bind that attaches them.
`default_nettype none

module fupa_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                done,
    input wire fupa_pkg::pool_rsp_t result
);

    import fupa_pkg::*;

    // every accepted item gets its result strobe
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("result strobe missing two cycles after accept");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != STAT_GRANT |-> result.unit_index == '0)
        else $error("unit index not zero on a non-grant result");

endmodule

bind fixed_unit_pool_allocator fupa_checker u_fupa_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .result(result)
);

`default_nettype wire
